>>> rtl/q24alu_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// Used by the front end, the queue and the back end. No dependencies.
`default_nettype none
package q24alu_pkg;

  // Number of fraction bits in the fixed-point format
  localparam int FRAC_BITS = 8;
  // Operand and result width
  localparam int DATA_W    = 32;
  // Magnitude width of the shifted dividend, also the number of divide steps
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  // Queue depth and pointer width
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_INT = 4'd8
  } op_t;

  // One classified item between front and back end
  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] res;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic                     dz;
    logic                     ovf;
  } q_item_t;

endpackage
`default_nettype wire

>>> rtl/q24_8_fixed_point_alu.sv
// Top level of the Q24.8 fixed-point ALU: front end, queue and back end.
// Depends on q24alu_pkg, q24alu_front, q24alu_queue and q24alu_back.
//
//   channel | dir | handshake            | content
//   in      | in  | in_tvalid/in_tready  | operation, operand_a, operand_b
//   out     | out | out_tvalid/out_tready| result_value and five flags
//
// One item per cycle sustained while the output is not stalled; each item passes
// from the input transfer through the queue, the multiply stage, the divider load
// stage, the 40-stage divide pipeline and the output register to the result.
// Reset clears only valid bits, queue pointers and the queue fill count.
// An output stall freezes the back end; the queue then absorbs up to four
// items before in_tready drops.
`default_nettype none
module q24_8_fixed_point_alu import q24alu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // [3:0] operation, [35:4] operand_a, [67:36] operand_b
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // [31:0] result_value, [32] a_less, [33] a_equal,
                                      // [34] a_greater, [35] divide_by_zero, [36] overflowed
);

  q_item_t f_item;
  q_item_t q_head;
  q_item_t b_item;
  logic    q_full;
  logic    q_ne;
  logic    b_en;

  q24alu_front u_front (
    .op   (in_tdata[3:0]),
    .a    (in_tdata[35:4]),
    .b    (in_tdata[67:36]),
    .item (f_item)
  );

  assign in_tready = !q_full;

  q24alu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_item (f_item),
    .full      (q_full),
    .pop       (b_en && q_ne),
    .head      (q_head),
    .not_empty (q_ne)
  );

  q24alu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_ne),
    .in_item  (q_head),
    .en       (b_en),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_item (b_item)
  );

  assign out_tdata = {3'b000, b_item.ovf, b_item.dz, b_item.greater, b_item.equal,
                      b_item.less, b_item.res};

endmodule
`default_nettype wire

>>> rtl/q24alu_front.sv
// Front end of the fixed-point ALU: compares the operands and finishes the
// single-cycle operations. Depends on q24alu_pkg.
`default_nettype none
module q24alu_front import q24alu_pkg::*; (
  input  wire logic [3:0]               op,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output q_item_t                       item
);

  logic signed [DATA_W:0] sum;
  logic signed [DATA_W:0] diff;
  logic signed [DATA_W:0] inc;
  logic signed [DATA_W:0] dec;
  logic                   less;
  logic                   equal;

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Widened add paths; overflow shows as a mismatch of the two top bits
  assign sum  = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  assign inc  = {a[DATA_W-1], a} + (DATA_W+1)'(1);
  assign dec  = {a[DATA_W-1], a} - (DATA_W+1)'(1);
  assign less  = a < b;
  assign equal = a == b;

  always_comb begin
    item         = '0;
    item.op      = op;
    item.a       = a;
    item.b       = b;
    item.less    = less;
    item.equal   = equal;
    item.greater = !less && !equal;
    case (op)
      OP_ADD: begin
        item.ovf = sum[DATA_W] != sum[DATA_W-1];
        item.res = item.ovf ? (sum[DATA_W] ? SMIN : SMAX) : sum[DATA_W-1:0];
      end
      OP_SUB: begin
        item.ovf = diff[DATA_W] != diff[DATA_W-1];
        item.res = item.ovf ? (diff[DATA_W] ? SMIN : SMAX) : diff[DATA_W-1:0];
      end
      OP_INC: begin
        item.ovf = inc[DATA_W] != inc[DATA_W-1];
        item.res = item.ovf ? SMAX : inc[DATA_W-1:0];
      end
      OP_DEC: begin
        item.ovf = dec[DATA_W] != dec[DATA_W-1];
        item.res = item.ovf ? SMIN : dec[DATA_W-1:0];
      end
      OP_MIN:  item.res = less ? a : b;
      OP_MAX:  item.res = (!less && !equal) ? a : b;
      OP_INT:  item.res = a >>> FRAC_BITS;
      // divide by zero is settled here; the back end leaves it alone
      OP_DIV:  item.dz  = b == '0;
      default: item.res = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/q24alu_queue.sv
// Short FIFO between front and back end of the fixed-point ALU.
// Depends on q24alu_pkg.
`default_nettype none
module q24alu_queue import q24alu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  q_item_t   push_item,
  output logic      full,
  input  wire logic pop,
  output q_item_t   head,
  output logic      not_empty
);

  q_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/q24alu_back.sv
// Back end of the fixed-point ALU: pipelined multiply with rounding and a
// one-bit-per-stage restoring divider. Depends on q24alu_pkg.
`default_nettype none
module q24alu_back import q24alu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_vld,
  input  q_item_t   in_item,
  output logic      en,
  output logic      out_vld,
  input  wire logic out_rdy,
  output q_item_t   out_item
);

  typedef struct packed {
    logic                    vld;
    q_item_t                 item;
    logic                    neg;
    logic [DATA_W:0]         rem;
    logic [DVD_W-1:0]        dvd;
    logic [DVD_W-1:0]        quo;
    logic [DATA_W-1:0]       dvs;
  } div_st_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res;
    logic                     ovf;
  } sat_t;

  // one restoring division step: one quotient bit
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t         r;
    logic [DATA_W:0] t;
    begin
      r = s;
      t = {s.rem[DATA_W-1:0], s.dvd[DVD_W-1]};
      if (t >= {1'b0, s.dvs}) begin
        r.rem = t - {1'b0, s.dvs};
        r.quo = {s.quo[DVD_W-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.quo = {s.quo[DVD_W-2:0], 1'b0};
      end
      r.dvd = {s.dvd[DVD_W-2:0], 1'b0};
      return r;
    end
  endfunction

  // apply sign to a rounded magnitude and clamp to the 32-bit range
  function automatic sat_t sat_mag(input logic neg, input logic [2*DATA_W-1:0] mag);
    sat_t r;
    begin
      r.ovf = 1'b0;
      if (!neg && mag > {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}) begin
        r.ovf = 1'b1;
        r.res = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (neg && mag > {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
        r.ovf = 1'b1;
        r.res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        r.res = neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
      end
      return r;
    end
  endfunction

  // whole pipeline moves when the output register is free or drained
  assign en = !out_vld || out_rdy;

  // prep stage: product and divide magnitudes
  logic                       p_vld_r;
  q_item_t                    p_item_r;
  logic signed [2*DATA_W-1:0] p_prod_r;
  logic [DVD_W-1:0]           p_dvd_r;
  logic [DATA_W-1:0]          p_dvs_r;
  logic                       p_neg_r;
  logic [DATA_W-1:0]          a_mag;
  logic [DATA_W-1:0]          b_mag;

  assign a_mag = in_item.a[DATA_W-1] ? -in_item.a : in_item.a;
  assign b_mag = in_item.b[DATA_W-1] ? -in_item.b : in_item.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_item_r <= in_item;
      p_prod_r <= in_item.a * in_item.b;
      p_dvd_r  <= {a_mag, {FRAC_BITS{1'b0}}};
      p_dvs_r  <= b_mag;
      p_neg_r  <= in_item.a[DATA_W-1] ^ in_item.b[DATA_W-1];
    end
  end

  // multiply rounding: half away from zero on the dropped fraction bits
  logic [2*DATA_W-1:0] prod_mag;
  logic [2*DATA_W-1:0] prod_q;
  sat_t                mul_sat;
  div_st_t             d0;

  assign prod_mag = p_prod_r[2*DATA_W-1] ? -p_prod_r : p_prod_r;
  assign prod_q   = (prod_mag >> FRAC_BITS) + (2*DATA_W)'(prod_mag[FRAC_BITS-1]);
  assign mul_sat  = sat_mag(p_prod_r[2*DATA_W-1], prod_q);

  always_comb begin
    d0      = '0;
    d0.vld  = p_vld_r;
    d0.item = p_item_r;
    d0.dvd  = p_dvd_r;
    d0.dvs  = p_dvs_r;
    d0.neg  = p_neg_r;
    if (p_item_r.op == OP_MUL) begin
      d0.item.res = mul_sat.res;
      d0.item.ovf = mul_sat.ovf;
    end
  end

  // divider stages, one quotient bit each
  div_st_t d_r [DVD_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r[0].vld <= 1'b0;
    end else if (en) begin
      d_r[0].vld <= d0.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0].item <= d0.item;
      d_r[0].neg  <= d0.neg;
      d_r[0].rem  <= d0.rem;
      d_r[0].dvd  <= d0.dvd;
      d_r[0].quo  <= d0.quo;
      d_r[0].dvs  <= d0.dvs;
    end
  end

  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    div_st_t nx;
    assign nx = div_step(d_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_r[k+1].vld <= 1'b0;
      end else if (en) begin
        d_r[k+1].vld <= d_r[k].vld;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k+1].item <= nx.item;
        d_r[k+1].neg  <= nx.neg;
        d_r[k+1].rem  <= nx.rem;
        d_r[k+1].dvd  <= nx.dvd;
        d_r[k+1].quo  <= nx.quo;
        d_r[k+1].dvs  <= nx.dvs;
      end
    end
  end

  // divide rounding: up when twice the remainder reaches the divisor
  div_st_t             dl;
  logic [2*DATA_W-1:0] div_q;
  sat_t                div_sat;
  q_item_t             fin;

  assign dl      = d_r[DVD_W];
  assign div_q   = (2*DATA_W)'(dl.quo) +
                   (2*DATA_W)'({dl.rem, 1'b0} >= {2'b00, dl.dvs});
  assign div_sat = sat_mag(dl.neg, div_q);

  always_comb begin
    fin = dl.item;
    if (dl.item.op == OP_DIV && !dl.item.dz) begin
      fin.res = div_sat.res;
      fin.ovf = div_sat.ovf;
    end
  end

  // output register
  logic    out_vld_r;
  q_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= fin;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule
`default_nettype wire

>>> tb/q24_8_fixed_point_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed table plus random items.
// Depends on q24alu_pkg and the q24_8_fixed_point_alu RTL.
`timescale 1ns / 100ps
module q24_8_fixed_point_alu_tb;
  import q24alu_pkg::*;

  localparam int LATENCY     = 43;
  localparam int N_RANDOM    = 1130;
  localparam int STALL_LIMIT = 4000;

  // Laid out like out_tdata: value in the low bits, overflow flag on top
  typedef struct packed {
    logic               ovf;
    logic               dz;
    logic               greater;
    logic               equal;
    logic               less;
    logic signed [31:0] value;
  } alu_result_t;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 has_exp;
    logic signed [31:0] exp_value;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  alu_result_t pending_results[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_off;
  bit          calm;

  q24_8_fixed_point_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),  // [3:0] operation, [35:4] operand_a, [67:36] operand_b
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)  // [31:0] value, [32] less, [33] equal, [34] greater, [35] dz, [36] ovf
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Round num / den half away from zero, den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    longint r;
    mag = (num < 0) ? -num : num;
    q   = mag / den;
    r   = mag % den;
    if (r >= den - r) q++;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp32(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Expected ALU result for one operation
  function automatic alu_result_t alu_compute(logic [3:0] op, logic signed [31:0] a_in,
                                              logic signed [31:0] b_in);
    alu_result_t r;
    longint a;
    longint b;
    longint v;
    logic   ovf;
    a   = a_in;
    b   = b_in;
    v   = 0;
    ovf = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: v = clamp32(a + b, ovf);
      OP_SUB: v = clamp32(a - b, ovf);
      OP_MUL: v = clamp32(round_div(a * b, longint'(1) << FRAC_BITS), ovf);
      OP_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else v = clamp32(round_div(a * (longint'(1) << FRAC_BITS), (b < 0) ? -b : b)
                         * ((b < 0) ? -1 : 1), ovf);
      end
      OP_MIN: v = (a < b) ? a : b;
      OP_MAX: v = (a > b) ? a : b;
      OP_INC: v = clamp32(a + 1, ovf);
      OP_DEC: v = clamp32(a - 1, ovf);
      OP_INT: v = a >>> FRAC_BITS;
      default: v = 0;
    endcase
    r.value   = v[31:0];
    r.ovf     = ovf;
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Drive one item and wait for its transfer
  task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(alu_compute(op, a, b));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(2) == 0 ? 32'sh7fffffff :
                ($urandom_range(1) ? 32'sh80000000 : 32'sh0);
      1: return $signed($urandom_range(4095)) - 2048;
      2: return $signed($urandom_range(65535)) - 32768;
      3: return $signed($urandom) >>> $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random ready, steady ready while calm, one long hold-off while the queue fills
  initial begin
    out_tready = 1'b0;
    hold_off   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    alu_result_t want;
    alu_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[36:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) report_mismatch("result_value", got, want);
        if (got.less !== want.less) report_mismatch("a_less", got, want);
        if (got.equal !== want.equal) report_mismatch("a_equal", got, want);
        if (got.greater !== want.greater) report_mismatch("a_greater", got, want);
        if (got.dz !== want.dz) report_mismatch("divide_by_zero", got, want);
        if (got.ovf !== want.ovf) report_mismatch("overflowed", got, want);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("q24_8_fixed_point_alu regression: fail");
      $finish;
    end
  end

  initial begin
    vector_t     table_rows[$];
    vector_t     row;
    alu_result_t hand;
    int          wait_cycles;
    logic [3:0]  op;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    error_count = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: op, a, b, expected value where obvious
    table_rows = '{
      '{OP_ADD, 32'sh7fffffff, 32'sh1, 1, 32'sh7fffffff},
      '{OP_ADD, 32'sh80000000, 32'sh80000000, 1, 32'sh80000000},
      '{OP_SUB, 32'sh80000000, 32'sh1, 1, 32'sh80000000},
      '{OP_SUB, 32'sh7fffffff, 32'sh80000000, 1, 32'sh7fffffff},
      '{OP_MUL, 32'sh180, 32'sh180, 0, 0},
      '{OP_MUL, 32'sh1, 32'sh80, 0, 0},
      '{OP_MUL, -32'sh1, 32'sh80, 0, 0},
      '{OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 1, 32'sh7fffffff},
      '{OP_MUL, 32'sh80000000, 32'sh80000000, 1, 32'sh7fffffff},
      '{OP_DIV, 32'sh100, 32'sh0, 1, 32'sh0},
      '{OP_DIV, 32'sh100, 32'sh300, 0, 0},
      '{OP_DIV, 32'sh80000000, -32'sh1, 1, 32'sh7fffffff},
      '{OP_DIV, 32'sh7fffffff, 32'sh1, 1, 32'sh7fffffff},
      '{OP_DIV, -32'sh180, 32'sh200, 0, 0},
      '{OP_MIN, 32'sh80000000, 32'sh7fffffff, 1, 32'sh80000000},
      '{OP_MAX, 32'sh80000000, 32'sh7fffffff, 1, 32'sh7fffffff},
      '{OP_MIN, 32'sh55, 32'sh55, 1, 32'sh55},
      '{OP_INC, 32'sh7fffffff, 32'sh0, 1, 32'sh7fffffff},
      '{OP_DEC, 32'sh80000000, 32'sh0, 1, 32'sh80000000},
      '{OP_DEC, 32'sh0, 32'sh0, 1, -32'sh1},
      '{OP_INT, -32'sh1, 32'sh0, 1, -32'sh1},
      '{OP_INT, 32'sh7fffffff, 32'sh0, 1, 32'sh7fffff},
      '{OP_INT, 32'sh80000000, 32'sh0, 1, -32'sh800000},
      '{4'd9, 32'sh1234, 32'sh1234, 1, 32'sh0},
      '{4'd15, -32'sh1, 32'sh7fffffff, 1, 32'sh0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      hand = alu_compute(row.op, row.a, row.b);
      if (row.has_exp && hand.value !== row.exp_value)
        report_mismatch("table row", hand, row.exp_value);
      send_item(row.op, row.a, row.b);
    end

    // Random items; one calm stretch and one long receiver hold-off
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      send_item(op, rand_operand(), ($urandom_range(15) == 0) ? 32'sh0 : rand_operand());
    end
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("q24_8_fixed_point_alu regression: pass");
    end else begin
      $display("q24_8_fixed_point_alu regression: fail");
    end
    $finish;
  end

endmodule
